// ===== hw/rtl/two_level_page_table_manager_macros.svh =====
// ----------------------------------------------------------------------------
// Two-level page table manager assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TWO_LEVEL_PAGE_TABLE_MANAGER_MACROS_SVH
`define TWO_LEVEL_PAGE_TABLE_MANAGER_MACROS_SVH

// Condition that must hold at every clock edge out of reset.
`define TLPT_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Antecedent in one cycle implies the consequent in the next.
`define TLPT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/tlpt_pkg.sv =====
// ----------------------------------------------------------------------------
// Two-level page table manager package
// Codes, sequencer states and the command and status words between the
// controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package tlpt_pkg;

	localparam int IDX_W     = 10;
	localparam int DIR_DEPTH = 1024;
	localparam int CFG_IDX_W = 1;

	localparam logic [IDX_W-1:0] IDX_LAST = 10'h3FF;

	typedef logic [1:0] action_t;
	localparam action_t ACT_MAP   = 2'd0;
	localparam action_t ACT_UNMAP = 2'd1;
	localparam action_t ACT_XLATE = 2'd2;
	localparam action_t ACT_NOP   = 2'd3;

	typedef logic [1:0] status_t;
	localparam status_t ST_OK       = 2'd0;
	localparam status_t ST_NO_TABLE = 2'd1;
	localparam status_t ST_CONFLICT = 2'd2;
	localparam status_t ST_UNMAPPED = 2'd3;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	localparam cfg_idx_t CFG_KEEP_MASK = 1'd0;
	localparam cfg_idx_t CFG_CHECK     = 1'd1;

	typedef enum logic [2:0] {
		S_CLR_DIR,
		S_IDLE,
		S_DIR,
		S_CLR_TBL,
		S_TBL_RD,
		S_TBL
	} state_t;

	typedef struct packed {
		logic    cnt_inc;
		logic    dir_clr;
		logic    capture;
		logic    alloc;
		logic    tbl_clr;
		logic    tbl_rd;
		logic    rd_from_dir;
		logic    tbl_wr;
		logic    tbl_zero;
		logic    res_valid;
		status_t res_status;
		logic    res_phys;
	} cmd_t;

	typedef struct packed {
		logic    cnt_last;
		logic    dir_present;
		logic    pool_empty;
		logic    entry_present;
		logic    conflict;
		action_t action;
	} sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/two_level_page_table_manager.sv =====
// ----------------------------------------------------------------------------
// Two-level page table manager
// Keeps a 1024-entry page directory and a pool of second-level tables, and
// maps, unmaps or translates one virtual address per request, or does a no-op.
// ----------------------------------------------------------------------------
// A request word (action, vaddr, paddr, flags) is taken at a rising edge with
// start high and busy low. Its result word (status, xlate_addr) is on the
// result ports for one cycle with done high; the receiver takes it there and
// cannot stall, and the next request may be taken in that same cycle.
// A request that reads its table passes through the registered directory
// read, the registered table read, and the update and result register. A
// request that ends at the directory passes only through the directory read
// and the result register. Busy stays high until a request has finished, so
// no new request is taken before the last one's result is given.
// A map that allocates a table clears it first, one entry a cycle, before
// its table read.
// After reset the directory is cleared, one entry a cycle, with busy high.
// Configuration writes (valid and ready, index and data) are taken at
// any time; ready is always high, and they are meant for idle time.
// ----------------------------------------------------------------------------
`default_nettype none

module two_level_page_table_manager #(
	parameter int NUM_TABLES = 16
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	output logic                                busy,
	input  wire logic [1:0]                     action,
	input  wire logic [31:0]                    vaddr,
	input  wire logic [31:0]                    paddr,
	input  wire logic [11:0]                    flags,
	output logic                                done,
	output logic [1:0]                          status,
	output logic [31:0]                         xlate_addr,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [tlpt_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [11:0]                    cfg_data
);

	tlpt_pkg::cmd_t cmd;
	tlpt_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	tlpt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (sts),
		.cmd    (cmd)
	);

	tlpt_dp #(
		.NUM_TABLES (NUM_TABLES)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.action     (action),
		.vaddr      (vaddr),
		.paddr      (paddr),
		.flags      (flags),
		.cfg_valid  (cfg_valid),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.done       (done),
		.status     (status),
		.xlate_addr (xlate_addr)
	);

endmodule

`default_nettype wire

// ===== hw/rtl/tlpt_ctrl.sv =====
// ----------------------------------------------------------------------------
// Page table manager controller
// Sequences the directory clear after reset, the directory and table reads
// of each request, table clearing on allocation, and the result.
// ----------------------------------------------------------------------------
`default_nettype none

module tlpt_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               busy,
	input  tlpt_pkg::sts_t     sts,
	output tlpt_pkg::cmd_t     cmd
);

	tlpt_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tlpt_pkg::S_CLR_DIR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = 1'b1;
		unique case (state_q)
			tlpt_pkg::S_CLR_DIR: begin
				cmd.dir_clr = 1'b1;
				cmd.cnt_inc = 1'b1;
				if (sts.cnt_last) begin
					state_d = tlpt_pkg::S_IDLE;
				end
			end
			tlpt_pkg::S_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.capture = 1'b1;
					state_d     = tlpt_pkg::S_DIR;
				end
			end
			tlpt_pkg::S_DIR: begin
				unique case (sts.action) inside
					tlpt_pkg::ACT_MAP: begin
						if (sts.dir_present) begin
							cmd.tbl_rd      = 1'b1;
							cmd.rd_from_dir = 1'b1;
							state_d         = tlpt_pkg::S_TBL;
						end else if (sts.pool_empty) begin
							cmd.res_valid  = 1'b1;
							cmd.res_status = tlpt_pkg::ST_NO_TABLE;
							state_d        = tlpt_pkg::S_IDLE;
						end else begin
							cmd.alloc = 1'b1;
							state_d   = tlpt_pkg::S_CLR_TBL;
						end
					end
					tlpt_pkg::ACT_UNMAP, tlpt_pkg::ACT_XLATE: begin
						if (sts.dir_present) begin
							cmd.tbl_rd      = 1'b1;
							cmd.rd_from_dir = 1'b1;
							state_d         = tlpt_pkg::S_TBL;
						end else begin
							cmd.res_valid  = 1'b1;
							cmd.res_status = tlpt_pkg::ST_UNMAPPED;
							state_d        = tlpt_pkg::S_IDLE;
						end
					end
					default: begin
						cmd.res_valid  = 1'b1;
						cmd.res_status = tlpt_pkg::ST_OK;
						state_d        = tlpt_pkg::S_IDLE;
					end
				endcase
			end
			tlpt_pkg::S_CLR_TBL: begin
				cmd.tbl_clr = 1'b1;
				cmd.cnt_inc = 1'b1;
				if (sts.cnt_last) begin
					state_d = tlpt_pkg::S_TBL_RD;
				end
			end
			tlpt_pkg::S_TBL_RD: begin
				cmd.tbl_rd = 1'b1;
				state_d    = tlpt_pkg::S_TBL;
			end
			tlpt_pkg::S_TBL: begin
				cmd.res_valid = 1'b1;
				state_d       = tlpt_pkg::S_IDLE;
				unique case (sts.action) inside
					tlpt_pkg::ACT_MAP: begin
						if (sts.conflict) begin
							cmd.res_status = tlpt_pkg::ST_CONFLICT;
						end else begin
							cmd.tbl_wr     = 1'b1;
							cmd.res_status = tlpt_pkg::ST_OK;
						end
					end
					tlpt_pkg::ACT_UNMAP: begin
						if (sts.entry_present) begin
							cmd.tbl_wr     = 1'b1;
							cmd.tbl_zero   = 1'b1;
							cmd.res_status = tlpt_pkg::ST_OK;
						end else begin
							cmd.res_status = tlpt_pkg::ST_UNMAPPED;
						end
					end
					tlpt_pkg::ACT_XLATE: begin
						if (sts.entry_present) begin
							cmd.res_phys   = 1'b1;
							cmd.res_status = tlpt_pkg::ST_OK;
						end else begin
							cmd.res_status = tlpt_pkg::ST_UNMAPPED;
						end
					end
					default: begin
						cmd.res_status = tlpt_pkg::ST_OK;
					end
				endcase
			end
			default: begin
				state_d = tlpt_pkg::S_CLR_DIR;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== hw/rtl/tlpt_dp.sv =====
// ----------------------------------------------------------------------------
// Page table manager datapath
// Request and configuration registers, the directory and table memories,
// the table pool counter, the sweep counter and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "two_level_page_table_manager_macros.svh"

module tlpt_dp #(
	parameter int NUM_TABLES = 16
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  tlpt_pkg::cmd_t                      cmd,
	output tlpt_pkg::sts_t                      sts,
	input  wire logic [1:0]                     action,
	input  wire logic [31:0]                    vaddr,
	input  wire logic [31:0]                    paddr,
	input  wire logic [11:0]                    flags,
	input  wire logic                           cfg_valid,
	input  wire logic [tlpt_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [11:0]                    cfg_data,
	output logic                                done,
	output logic [1:0]                          status,
	output logic [31:0]                         xlate_addr
);

	localparam int SLOT_W    = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
	localparam int CNT_W     = $clog2(NUM_TABLES + 1);
	localparam int TA_W      = SLOT_W + tlpt_pkg::IDX_W;
	localparam int TBL_DEPTH = NUM_TABLES * tlpt_pkg::DIR_DEPTH;
	localparam logic [CNT_W-1:0] POOL_SIZE = CNT_W'(NUM_TABLES);

	logic [SLOT_W:0]              dir_mem [tlpt_pkg::DIR_DEPTH];
	logic [31:0]                  tbl_mem [TBL_DEPTH];

	tlpt_pkg::action_t            act_q;
	logic [31:0]                  va_q;
	logic [31:0]                  pa_q;
	logic [11:0]                  fl_q;
	logic [11:0]                  keep_mask_q;
	logic                         check_q;
	logic [tlpt_pkg::IDX_W-1:0]   cnt_q;
	logic [CNT_W-1:0]             next_free_q;
	logic [SLOT_W-1:0]            slot_q;
	logic [SLOT_W:0]              dir_rdata_q;
	logic [31:0]                  tbl_rdata_q;
	logic                         done_q;
	tlpt_pkg::status_t            status_q;
	logic [31:0]                  phys_q;

	logic [tlpt_pkg::IDX_W-1:0]   dir_waddr;
	logic [SLOT_W:0]              dir_wdata;
	logic [SLOT_W-1:0]            rd_slot;
	logic [TA_W-1:0]              tbl_raddr;
	logic [TA_W-1:0]              tbl_waddr;
	logic [31:0]                  tbl_wdata;
	logic [31:0]                  new_entry;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_mask_q <= 12'hFFF;
			check_q     <= 1'b1;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				tlpt_pkg::CFG_KEEP_MASK: keep_mask_q <= cfg_data;
				tlpt_pkg::CFG_CHECK:     check_q     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			act_q <= action;
			va_q  <= vaddr;
			pa_q  <= paddr;
			fl_q  <= flags;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			next_free_q <= '0;
		end else begin
			if (cmd.cnt_inc) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.alloc) begin
				next_free_q <= next_free_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.alloc) begin
			slot_q <= next_free_q[SLOT_W-1:0];
		end else if (cmd.tbl_rd && cmd.rd_from_dir) begin
			slot_q <= dir_rdata_q[SLOT_W-1:0];
		end
	end

	assign dir_waddr = cmd.dir_clr ? cnt_q : va_q[31:22];
	assign dir_wdata = cmd.dir_clr ? '0 : {1'b1, next_free_q[SLOT_W-1:0]};

	always_ff @(posedge clk) begin
		if (cmd.dir_clr || cmd.alloc) begin
			dir_mem[dir_waddr] <= dir_wdata;
		end
		if (cmd.capture) begin
			dir_rdata_q <= dir_mem[vaddr[31:22]];
		end
	end

	assign rd_slot   = cmd.rd_from_dir ? dir_rdata_q[SLOT_W-1:0] : slot_q;
	assign tbl_raddr = {rd_slot, va_q[21:12]};
	assign tbl_waddr = cmd.tbl_clr ? {slot_q, cnt_q} : {slot_q, va_q[21:12]};
	assign new_entry = {pa_q[31:12], fl_q & keep_mask_q};
	assign tbl_wdata = (cmd.tbl_clr || cmd.tbl_zero) ? '0 : new_entry;

	always_ff @(posedge clk) begin
		if (cmd.tbl_clr || cmd.tbl_wr) begin
			tbl_mem[tbl_waddr] <= tbl_wdata;
		end
		if (cmd.tbl_rd) begin
			tbl_rdata_q <= tbl_mem[tbl_raddr];
		end
	end

	always_comb begin
		sts.cnt_last      = (cnt_q == tlpt_pkg::IDX_LAST);
		sts.dir_present   = dir_rdata_q[SLOT_W];
		sts.pool_empty    = (next_free_q == POOL_SIZE);
		sts.entry_present = tbl_rdata_q[0];
		sts.conflict      = check_q && tbl_rdata_q[0] && (tbl_rdata_q[31:12] != pa_q[31:12]);
		sts.action        = act_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_valid) begin
			status_q <= cmd.res_status;
			phys_q   <= cmd.res_phys ? {tbl_rdata_q[31:12], va_q[11:0]} : '0;
		end
	end

	assign done       = done_q;
	assign status     = status_q;
	assign xlate_addr = phys_q;

	`TLPT_ASSERT_NEXT(a_done_single, done_q, !done_q, "result strobe held for two cycles")
	`TLPT_ASSERT(a_alloc_in_pool, !cmd.alloc || (next_free_q < POOL_SIZE),
		"table allocated from an empty pool")
	`TLPT_ASSERT(a_pool_bound, next_free_q <= POOL_SIZE, "pool counter beyond pool size")
	`TLPT_ASSERT(a_phys_ok, !(done_q && (phys_q != 32'd0)) || (status_q == tlpt_pkg::ST_OK),
		"translated address given with a failing status")

endmodule

`default_nettype wire
